// ===== design/metaball_field_renderer_assert.svh =====
// Assertion macros used by the checker file of the metaball field renderer.
`ifndef METABALL_FIELD_RENDERER_ASSERT_SVH
`define METABALL_FIELD_RENDERER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define MFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is held.
`define MFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/mfr_pkg.sv =====
// Package of types and constants for the metaball field renderer.
package mfr_pkg;

    // Item kinds.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BALLS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOB_SIZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOW_FACTOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_OUTPUT = 3'd7;

    // Fixed-point widths.
    localparam int NUM_W  = 49;  // blob_size * tint * 2^24
    localparam int DEN_W  = 45;  // glow_factor * squared distance
    localparam int CONT_W = 17;  // Q0.16 with 65536 as one
    localparam logic [CONT_W-1:0] ONE_Q16 = 17'h10000;

    // One ball: position and velocity, signed Q8.8.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
    } t_ball;

endpackage

// ===== design/mfr_item_if.sv =====
// Input channel of the metaball field renderer.
interface mfr_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [3:0]         ball_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [3:0]         pixel_x;
    logic [3:0]         pixel_y;

    modport source (output valid, mode, ball_index, pos_x, pos_y, vel_x, vel_y,
                    pixel_x, pixel_y, input ready);
    modport sink (input valid, mode, ball_index, pos_x, pos_y, vel_x, vel_y,
                  pixel_x, pixel_y, output ready);
endinterface

// ===== design/mfr_result_if.sv =====
// Result channel of the metaball field renderer.
interface mfr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, item_kind, out_red, out_green, out_blue, input ready);
    modport sink (input valid, item_kind, out_red, out_green, out_blue, output ready);
endinterface

// ===== design/mfr_ball_cell.sv =====
// One cell of the ball ring: holds one ball, loads it or takes its neighbour's.
module mfr_ball_cell (
    input  logic          i_clk,
    input  logic          i_load_en,
    input  mfr_pkg::t_ball i_load_ball,
    input  logic          i_shift_en,
    input  mfr_pkg::t_ball i_shift_ball,
    output mfr_pkg::t_ball o_ball
);
    import mfr_pkg::*;

    t_ball r_ball;

    // A load writes the cell; a rotation takes the neighbour's ball.
    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_ball <= i_load_ball;
        end else if (i_shift_en) begin
            r_ball <= i_shift_ball;
        end
    end

    assign o_ball = r_ball;
endmodule

// ===== design/mfr_divider.sv =====
// Restoring divider giving a saturated Q0.16 field contribution, one bit a cycle.
module mfr_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mfr_pkg::NUM_W-1:0]   i_num,
    input  logic [mfr_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [mfr_pkg::CONT_W-1:0]  o_quot
);
    import mfr_pkg::*;

    localparam int QB = 18;
    localparam int SW = 64;

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_step;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_dsh;
    logic [QB-1:0] r_q;
    logic          r_sat;
    logic          ge;

    assign ge = (r_rem >= r_dsh);

    // Control: the first step checks for overflow, the next QB steps make the bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'(QB)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, shifted divisor and quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SW'(i_num);
            r_dsh <= SW'(i_den) << QB;
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_dsh <= r_dsh >> 1;
            if (r_step == 5'd0) begin
                r_sat <= ge;
            end else begin
                r_q <= {r_q[QB-2:0], ge};
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_sat || (r_q > QB'(ONE_Q16))) ? ONE_Q16 : r_q[CONT_W-1:0];
endmodule

// ===== design/metaball_field_renderer.sv =====
// Metaball field renderer. Items are taken one at a time: ready is high only
// while no item is in work. A tick steps the ring through every cell, one
// position update per cycle for the active balls, and a render sums the
// contribution of each active ball, using three dividers of 19 steps that
// share one start. A finished result waits in an output register; the block
// takes the next item while it waits. Balls live in a ring of cells that
// rotates once per tick or render and is back in slot order afterwards.
module metaball_field_renderer #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16,
    parameter int MAX_BALLS   = 15,
    parameter int COLOR_MAX   = 255
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mfr_item_if.sink                        i_item,
    mfr_result_if.source                    o_result
);
    import mfr_pkg::*;

    localparam int KW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
    localparam logic signed [16:0] LIM_X = 17'(GRID_WIDTH * 256);
    localparam logic signed [16:0] LIM_Y = 17'(GRID_HEIGHT * 256);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_RLOAD = 3'd2;
    localparam logic [2:0] S_RMUL  = 3'd3;
    localparam logic [2:0] S_RDEN  = 3'd4;
    localparam logic [2:0] S_RDIV  = 3'd5;
    localparam logic [2:0] S_RACC  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Configuration registers.
    logic [3:0]  r_active;
    logic [15:0] r_blob;
    logic [8:0]  r_tint_r, r_tint_g, r_tint_b;
    logic [11:0] r_glow;
    logic [11:0] r_speed;
    logic        r_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 4'd4;
            r_blob   <= 16'd2048;
            r_tint_r <= 9'd256;
            r_tint_g <= 9'd51;
            r_tint_b <= 9'd179;
            r_glow   <= 12'd102;
            r_speed  <= 12'd307;
            r_invert <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_BALLS:  r_active <= i_cfg_data[3:0];
                CFG_BLOB_SIZE:     r_blob   <= i_cfg_data[15:0];
                CFG_TINT_RED:      r_tint_r <= i_cfg_data[8:0];
                CFG_TINT_GREEN:    r_tint_g <= i_cfg_data[8:0];
                CFG_TINT_BLUE:     r_tint_b <= i_cfg_data[8:0];
                CFG_GLOW_FACTOR:   r_glow   <= i_cfg_data[11:0];
                CFG_MOVE_SPEED:    r_speed  <= i_cfg_data[11:0];
                CFG_INVERT_OUTPUT: r_invert <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control registers.
    logic [2:0]    r_state;
    logic [KW-1:0] r_k;
    logic [1:0]    r_mode;
    logic [3:0]    r_px, r_py;
    logic          accept;
    logic          last_k;
    logic          k_active;
    logic [3:0]    eff_count;

    assign accept    = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign eff_count = (r_active > 4'(MAX_BALLS)) ? 4'(MAX_BALLS) : r_active;
    assign k_active  = (4'(r_k) < eff_count);
    assign last_k    = (r_k == KW'(MAX_BALLS - 1));

    // Ball ring.
    t_ball  ring [MAX_BALLS];
    t_ball  head;
    t_ball  tail;
    t_ball  load_ball;
    logic   shift_en;

    assign head = ring[0];
    assign load_ball = '{x: i_item.pos_x, y: i_item.pos_y, vx: i_item.vel_x,
                         vy: i_item.vel_y};
    assign shift_en = (r_state == S_TICK) || (r_state == S_RLOAD);

    for (genvar g = 0; g < MAX_BALLS; g++) begin : g_cell
        logic load_en;
        assign load_en = accept && (i_item.mode == MODE_LOAD)
                         && (i_item.ball_index == 4'(g));
        if (g == MAX_BALLS - 1) begin : g_last
            mfr_ball_cell u_cell (
                .i_clk        (i_clk),
                .i_load_en    (load_en),
                .i_load_ball  (load_ball),
                .i_shift_en   (shift_en),
                .i_shift_ball (tail),
                .o_ball       (ring[g])
            );
        end else begin : g_mid
            mfr_ball_cell u_cell (
                .i_clk        (i_clk),
                .i_load_en    (load_en),
                .i_load_ball  (load_ball),
                .i_shift_en   (shift_en),
                .i_shift_ball (ring[g+1]),
                .o_ball       (ring[g])
            );
        end
    end

    // Position update of the ball at the head of the ring.
    logic signed [28:0] prod_x, prod_y;
    logic signed [21:0] sum_x, sum_y;
    logic signed [15:0] nx, ny;
    t_ball              moved;

    always_comb begin
        prod_x = head.vx * $signed({1'b0, r_speed});
        prod_y = head.vy * $signed({1'b0, r_speed});
        sum_x  = 22'(head.x) + 22'(prod_x >>> 8);
        sum_y  = 22'(head.y) + 22'(prod_y >>> 8);
        nx = (sum_x > 22'sd32767) ? 16'sh7fff :
             (sum_x < -22'sd32768) ? 16'sh8000 : sum_x[15:0];
        ny = (sum_y > 22'sd32767) ? 16'sh7fff :
             (sum_y < -22'sd32768) ? 16'sh8000 : sum_y[15:0];
        moved.x  = nx;
        moved.y  = ny;
        moved.vx = head.vx;
        moved.vy = head.vy;
        if (nx[15] || ($signed({nx[15], nx}) > LIM_X)) begin
            moved.vx = (head.vx == 16'sh8000) ? 16'sh7fff : -head.vx;
        end
        if (ny[15] || ($signed({ny[15], ny}) > LIM_Y)) begin
            moved.vy = (head.vy == 16'sh8000) ? 16'sh7fff : -head.vy;
        end
        tail = ((r_state == S_TICK) && k_active) ? moved : head;
    end

    // Render datapath: squares, scaled distance, then division.
    logic signed [16:0] dx, dy;
    logic signed [33:0] sq_x, sq_y;
    logic [31:0]        r_dx2, r_dy2;
    logic [32:0]        d2;
    logic [28:0]        r_plo;
    logic [27:0]        r_phi;
    logic [DEN_W-1:0]   den;
    logic               div_start;
    logic [NUM_W-1:0]   num_r, num_g, num_b;
    logic [CONT_W-1:0]  q_r, q_g, q_b;
    logic [2:0]         div_done;
    logic [CONT_W-1:0]  r_acc_r, r_acc_g, r_acc_b;

    assign dx   = {head.x[15], head.x} - $signed({1'b0, r_px, 8'h00});
    assign dy   = {head.y[15], head.y} - $signed({1'b0, r_py, 8'h00});
    assign sq_x = dx * dx;
    assign sq_y = dy * dy;
    assign d2   = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign den  = (DEN_W'(r_phi) << 17) + DEN_W'(r_plo);
    assign div_start = (r_state == S_RDEN);
    assign num_r = {25'(r_blob * r_tint_r), 24'h000000};
    assign num_g = {25'(r_blob * r_tint_g), 24'h000000};
    assign num_b = {25'(r_blob * r_tint_b), 24'h000000};

    always_ff @(posedge i_clk) begin
        r_dx2 <= sq_x[31:0];
        r_dy2 <= sq_y[31:0];
        r_plo <= 29'(r_glow) * 29'(d2[16:0]);
        r_phi <= 28'(r_glow) * 28'(d2[32:17]);
    end

    mfr_divider u_div_r (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_r), .i_den(den), .o_done(div_done[0]), .o_quot(q_r));
    mfr_divider u_div_g (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_g), .i_den(den), .o_done(div_done[1]), .o_quot(q_g));
    mfr_divider u_div_b (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_b), .i_den(den), .o_done(div_done[2]), .o_quot(q_b));

    // Saturating channel sums.
    function automatic logic [CONT_W-1:0] sat_add(logic [CONT_W-1:0] a,
                                                  logic [CONT_W-1:0] b);
        logic [CONT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > (CONT_W+1)'(ONE_Q16)) ? ONE_Q16 : s[CONT_W-1:0];
    endfunction

    // Final scaling of a channel sum to the colour range.
    function automatic logic [7:0] finish(logic [CONT_W-1:0] s, logic inv);
        logic [CONT_W-1:0] v;
        logic [CONT_W+7:0] p;
        v = inv ? (ONE_Q16 - s) : s;
        p = v * 8'(COLOR_MAX);
        return p[23:16];
    endfunction

    // Sequencer.
    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_r, r_out_g, r_out_b;
    logic       out_free;

    assign out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (accept) begin
                        if (i_item.mode == MODE_TICK) begin
                            r_state <= S_TICK;
                        end else if (i_item.mode == MODE_RENDER) begin
                            r_state <= S_RLOAD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_TICK: begin
                    r_k <= r_k + KW'(1);
                    if (last_k) begin
                        r_state <= S_DONE;
                    end
                end
                S_RLOAD: begin
                    if (k_active) begin
                        r_state <= S_RMUL;
                    end else begin
                        r_k <= r_k + KW'(1);
                        if (last_k) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RMUL: r_state <= S_RDEN;
                S_RDEN: r_state <= S_RDIV;
                S_RDIV: begin
                    if (&div_done) begin
                        r_state <= S_RACC;
                    end
                end
                S_RACC: begin
                    r_k <= r_k + KW'(1);
                    r_state <= last_k ? S_DONE : S_RLOAD;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item latch, accumulators and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_item.mode;
            r_px    <= i_item.pixel_x;
            r_py    <= i_item.pixel_y;
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
        end else if (r_state == S_RACC) begin
            r_acc_r <= sat_add(r_acc_r, q_r);
            r_acc_g <= sat_add(r_acc_g, q_g);
            r_acc_b <= sat_add(r_acc_b, q_b);
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_kind <= r_mode;
            if (r_mode == MODE_RENDER) begin
                r_out_r <= finish(r_acc_r, r_invert);
                r_out_g <= finish(r_acc_g, r_invert);
                r_out_b <= finish(r_acc_b, r_invert);
            end else begin
                r_out_r <= '0;
                r_out_g <= '0;
                r_out_b <= '0;
            end
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.item_kind = r_out_kind;
    assign o_result.out_red   = r_out_r;
    assign o_result.out_green = r_out_g;
    assign o_result.out_blue  = r_out_b;
endmodule

// ===== design/mfr_checker.sv =====
// Port-level checks for the metaball field renderer, bound to the top level.
`include "metaball_field_renderer_assert.svh"

module mfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_green,
    input logic [7:0] i_out_blue
);
    import mfr_pkg::*;

    // A result that is not taken stays offered.
    `MFR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // Items other than renders carry black.
    `MFR_ASSERT_IMP(a_black, i_clk, i_rst_n, i_out_valid && (i_out_kind != MODE_RENDER), (i_out_red == 8'd0) && (i_out_green == 8'd0) && (i_out_blue == 8'd0))

    // After a transfer in, the block is busy in the next cycle.
    `MFR_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
endmodule

bind metaball_field_renderer mfr_checker u_mfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_kind  (o_result.item_kind),
    .i_out_red   (o_result.out_red),
    .i_out_green (o_result.out_green),
    .i_out_blue  (o_result.out_blue)
);
